// File: hdl/rlm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlm_pkg: shared definitions for the regex line matcher
// Field widths, command codes, pattern metacharacters and defaults.
// ----------------------------------------------------------------------------
package rlm_pkg;

  localparam int PATTERN_MAX_DEF = 32;

  localparam int CMD_W   = 2;
  localparam int IDX_W   = 5;
  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 6;
  localparam int COUNT_W = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD = 2'd0,
    CMD_TEXT = 2'd1,
    CMD_EOL  = 2'd2
  } cmd_t;

  localparam logic [BYTE_W-1:0] CH_CARET  = 8'h5E;
  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_DOT    = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;

endpackage

// File: hdl/regex_line_matcher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// regex_line_matcher: streaming line matcher for a small regular expression
// Literals, '.', x*, leading '^' and trailing '$', tracked as a position set.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle on the item channel unless stalled, set by the
//   position-set update (two log-depth star closures around the byte compare).
// An end-of-line word shows its result in the cycle after it is taken.
// The item channel stalls only while a result waits and the output stalls.
// Reset (rst, synchronous, active high) clears the line state, the count and
//   pattern_length; pattern store contents are left as they are.
module regex_line_matcher #(
  parameter int PATTERN_MAX = rlm_pkg::PATTERN_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration: pattern length register
  input  logic                          cfg_write,
  input  logic [rlm_pkg::LEN_W-1:0]     cfg_data,
  // item channel
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic [rlm_pkg::CMD_W-1:0]     command,
  input  logic [rlm_pkg::IDX_W-1:0]     pattern_index,
  input  logic [rlm_pkg::BYTE_W-1:0]    byte_value,
  // result channel
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic                          line_matched,
  output logic [rlm_pkg::COUNT_W-1:0]   matched_line_count
);
  import rlm_pkg::*;

  localparam int PM = PATTERN_MAX;
  localparam int AW = $clog2(PM);

  // Pattern store plus per-entry class flags, captured at load time so the
  // token decode below is plain bit logic.
  logic [BYTE_W-1:0] store_byte [PM];
  logic [PM-1:0]     is_nonzero;
  logic [PM-1:0]     is_star;
  logic [PM-1:0]     is_dot;
  logic [PM-1:0]     is_dollar;
  logic [PM-1:0]     is_caret;

  logic [LEN_W-1:0]   pattern_length;
  logic [PM:0]        active;
  logic               line_hit;
  logic               line_cut;
  logic               at_line_start;
  logic [COUNT_W-1:0] match_total;

  logic               accept;
  logic [AW-1:0]      store_addr;

  // Decoded pattern view; bit PM of each vector is the accept slot.
  logic [PM:0] live;       // position is inside the effective pattern
  logic [PM:0] live_prev;
  logic [PM:0] acc;        // one-hot at the effective length
  logic [PM:0] star_at;    // position is x of an x* token
  logic [PM:0] anchor_at;  // position is the trailing '$'
  logic [PM:0] single_at;  // position consumes one byte and moves on
  logic [PM:0] match_at;   // position accepts the current byte
  logic        anchored;

  logic [PM:0] start_set;
  logic [PM:0] seed_set;
  logic [PM:0] cur_set;
  logic [PM:0] raw_set;
  logic [PM:0] adv_set;
  logic        base_hit;
  logic        adv_hit;
  logic        eol_hit;
  logic        text_live;

  // Star closure as a stride-2 prefix scan: a live x* position also enables
  // whatever follows the token, transitively.
  function automatic logic [PM:0] star_close(input logic [PM:0] set_in,
                                             input logic [PM:0] star_in);
    logic [PM:0] g;
    logic [PM:0] p;
    logic [PM:0] g_prev;
    logic [PM:0] p_prev;
    g = set_in;
    p = '0;
    for (int j = 2; j <= PM; j++) begin
      p[j] = star_in[j-2];
    end
    for (int s = 2; s <= PM; s = s * 2) begin
      g_prev = g;
      p_prev = p;
      for (int j = s; j <= PM; j++) begin
        g[j] = g_prev[j] | (p_prev[j] & g_prev[j-s]);
        p[j] = p_prev[j] & p_prev[j-s];
      end
    end
    return g;
  endfunction

  assign accept     = item_valid && !item_stall;
  assign item_stall = result_valid && result_stall;
  assign store_addr = AW'(pattern_index);

  // Effective length: stop at the first zero byte or at pattern_length.
  always_comb begin
    live = '0;
    for (int i = 0; i < PM; i++) begin
      live[i] = is_nonzero[i] && (int'(pattern_length) > i);
    end
    for (int s = 1; s <= PM; s = s * 2) begin
      live_prev = live;
      for (int j = s; j <= PM; j++) begin
        live[j] = live_prev[j] & live_prev[j-s];
      end
    end
  end

  always_comb begin
    acc       = '0;
    star_at   = '0;
    anchor_at = '0;
    single_at = '0;
    match_at  = '0;
    acc[0]    = !live[0];
    for (int i = 1; i <= PM; i++) begin
      acc[i] = live[i-1] & !live[i];
    end
    for (int i = 0; i < PM - 1; i++) begin
      star_at[i] = live[i+1] & is_star[i+1];
    end
    for (int i = 0; i < PM; i++) begin
      anchor_at[i] = live[i] & is_dollar[i] & acc[i+1];
      single_at[i] = live[i] & !star_at[i] & !anchor_at[i];
      match_at[i]  = is_dot[i] | (store_byte[i] == byte_value);
    end
    anchored = live[0] & is_caret[0];
  end

  always_comb begin
    start_set    = '0;
    start_set[0] = !anchored;
    start_set[1] = anchored;
    seed_set     = star_close(start_set, star_at);
    cur_set      = at_line_start ? seed_set : active;
    base_hit     = line_hit | (at_line_start & (|(seed_set & acc)));

    // advance by one byte, then re-seed the start when unanchored
    raw_set    = (cur_set & match_at & star_at)
               | ((cur_set & match_at & single_at) << 1);
    raw_set[0] = raw_set[0] | !anchored;
    adv_set    = star_close(raw_set, star_at);
    adv_hit    = |(adv_set & acc);

    text_live  = !line_cut && (byte_value != CH_NUL);
    eol_hit    = base_hit | (|(cur_set & acc)) | (|(cur_set & anchor_at));
  end

  // Pattern store: no reset, entries are defined once loaded.
  always_ff @(posedge clk) begin
    if (accept && cmd_t'(command) == CMD_LOAD && int'(pattern_index) < PM) begin
      store_byte[store_addr] <= byte_value;
      is_nonzero[store_addr] <= (byte_value != CH_NUL);
      is_star[store_addr]    <= (byte_value == CH_STAR);
      is_dot[store_addr]     <= (byte_value == CH_DOT);
      is_dollar[store_addr]  <= (byte_value == CH_DOLLAR);
      is_caret[store_addr]   <= (byte_value == CH_CARET);
    end
  end

  // Line state, count and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      active         <= {{PM{1'b0}}, 1'b1};
      line_hit       <= 1'b0;
      line_cut       <= 1'b0;
      at_line_start  <= 1'b1;
      match_total    <= '0;
      result_valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        pattern_length <= cfg_data;
      end
      // load a result on end of line, else drop it once it is taken
      if (accept && cmd_t'(command) == CMD_EOL) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (accept) begin
        case (cmd_t'(command))
          CMD_TEXT: begin
            at_line_start <= 1'b0;
            active        <= text_live ? adv_set : cur_set;
            line_hit      <= base_hit | (text_live & adv_hit);
            line_cut      <= line_cut | (byte_value == CH_NUL);
          end
          CMD_EOL: begin
            active        <= cur_set;
            line_hit      <= 1'b0;
            line_cut      <= 1'b0;
            at_line_start <= 1'b1;
            line_matched  <= eol_hit;
            if (eol_hit && match_total != COUNT_MAX) begin
              match_total        <= match_total + 1'b1;
              matched_line_count <= match_total + 1'b1;
            end else begin
              matched_line_count <= match_total;
            end
          end
          default: begin
            // pattern loads are handled by the store; other codes do nothing
          end
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_eol_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept && cmd_t'(command) == CMD_EOL |=> result_valid)
    else $error("end of line did not raise a result");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid)
    else $error("item channel stalled with no pending result");

  a_eol_clears_line: assert property (@(posedge clk) disable iff (rst)
    accept && cmd_t'(command) == CMD_EOL |=> at_line_start && !line_hit && !line_cut)
    else $error("line state not cleared after end of line");

  a_count_steps: assert property (@(posedge clk) disable iff (rst)
    accept && cmd_t'(command) == CMD_EOL && eol_hit && match_total != COUNT_MAX
    |=> match_total == $past(match_total) + 1'b1)
    else $error("matched line count did not advance");

  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> match_total >= $past(match_total))
    else $error("matched line count went down");

endmodule
